// ===== hdl/tlca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_pkg: shared types for the lowest common ancestor block
// Field widths, table entry layout, controller state and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int FIELD_W = 7;

    typedef logic [FIELD_W-1:0] t_field;

    // One table entry: parent link and depth of a node.
    typedef struct packed {
        t_field parent;
        t_field depth;
    } t_entry;

    // LEVEL is the first climb cycle; LEVEL_A/LEVEL_B level the side that
    // started deeper; JOINT climbs both nodes together.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LEVEL   = 5'b00010,
        ST_LEVEL_A = 5'b00100,
        ST_LEVEL_B = 5'b01000,
        ST_JOINT   = 5'b10000
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic write;    // store one table entry
        logic load;     // take the two query nodes
        logic climb_a;  // move node a to its parent
        logic climb_b;  // move node b to its parent
        logic finish;   // capture the result
        logic fault;    // result is a step-bound fault
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic a_deeper;
        logic b_deeper;
        logic same_node;
        logic bound_hit;
    } t_status;

endpackage

// ===== hdl/tlca_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_dpath: tables, node registers and step counter
// Holds the parent/depth memory with two registered read ports, the two
// climbing node registers, the step counter and the result registers.
// ----------------------------------------------------------------------------
module tlca_dpath #(
    parameter int NODES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlca_pkg::t_cmd   i_cmd,
    input  tlca_pkg::t_field i_node,
    input  tlca_pkg::t_field i_parent_node,
    input  tlca_pkg::t_field i_node_depth,
    input  tlca_pkg::t_field i_first_node,
    input  tlca_pkg::t_field i_second_node,
    output tlca_pkg::t_status o_status,
    output tlca_pkg::t_field o_ancestor,
    output logic             o_fault
);
    import tlca_pkg::*;

    localparam int TBL   = 1 << FIELD_W;
    localparam int DEPTH = (NODES < TBL) ? NODES : TBL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(NODES + 1);

    logic [AW-1:0] w_slot [TBL];
    t_entry        mem [DEPTH];

    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_b, n_b;
    t_entry        r_rd_a, r_rd_b;
    logic [SW-1:0] r_steps, n_steps;
    t_field        r_ancestor;
    logic          r_fault;

    // Fold a 7-bit node field into the table range.
    for (genvar gi = 0; gi < TBL; gi++) begin : g_slot
        assign w_slot[gi] = AW'(gi % NODES);
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (i_cmd.load) begin
            n_a = w_slot[i_first_node];
            n_b = w_slot[i_second_node];
        end else begin
            if (i_cmd.climb_a) begin
                n_a = w_slot[r_rd_a.parent];
            end
            if (i_cmd.climb_b) begin
                n_b = w_slot[r_rd_b.parent];
            end
        end
    end

    always_comb begin
        n_steps = r_steps;
        if (i_cmd.load) begin
            n_steps = '0;
        end else if (i_cmd.climb_a || i_cmd.climb_b) begin
            n_steps = r_steps + SW'(1);
        end
    end

    // Table write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[w_slot[i_node]] <= '{parent: i_parent_node, depth: i_node_depth};
        end
    end

    // Read ports follow the next node values, so read data always matches r_a/r_b.
    always_ff @(posedge i_clk) begin
        r_rd_a <= mem[n_a];
        r_rd_b <= mem[n_b];
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        if (i_cmd.finish) begin
            r_ancestor <= i_cmd.fault ? '0 : FIELD_W'(r_a);
            r_fault    <= i_cmd.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else begin
            r_steps <= n_steps;
        end
    end

    assign o_status.a_deeper  = r_rd_a.depth > r_rd_b.depth;
    assign o_status.b_deeper  = r_rd_b.depth > r_rd_a.depth;
    assign o_status.same_node = r_a == r_b;
    assign o_status.bound_hit = r_steps >= SW'(NODES);

    assign o_ancestor = r_ancestor;
    assign o_fault    = r_fault;

endmodule

// ===== hdl/tlca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_ctrl: query sequencer
// Accepts items, steers the climb one parent link per cycle and raises the
// result strobe.
// ----------------------------------------------------------------------------
module tlca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_func,
    input  tlca_pkg::t_status i_status,
    output tlca_pkg::t_cmd    o_cmd,
    output logic              busy,
    output logic              o_valid
);
    import tlca_pkg::*;

    t_state r_state, n_state;
    logic   r_valid;
    logic   w_walk;
    logic   w_step_a;
    logic   w_step_b;
    t_state w_to;

    // Pick this cycle's climb. The side that starts deeper climbs alone while
    // it stays deeper; after that both climb together until the nodes meet.
    always_comb begin
        w_walk   = 1'b0;
        w_step_a = 1'b0;
        w_step_b = 1'b0;
        w_to     = ST_JOINT;
        case (r_state)
            ST_LEVEL: begin
                w_walk = 1'b1;
                if (i_status.a_deeper) begin
                    w_step_a = 1'b1;
                    w_to     = ST_LEVEL_A;
                end else if (i_status.b_deeper) begin
                    w_step_b = 1'b1;
                    w_to     = ST_LEVEL_B;
                end else begin
                    w_step_a = !i_status.same_node;
                    w_step_b = !i_status.same_node;
                end
            end
            ST_LEVEL_A: begin
                w_walk = 1'b1;
                if (i_status.a_deeper) begin
                    w_step_a = 1'b1;
                    w_to     = ST_LEVEL_A;
                end else begin
                    w_step_a = !i_status.same_node;
                    w_step_b = !i_status.same_node;
                end
            end
            ST_LEVEL_B: begin
                w_walk = 1'b1;
                if (i_status.b_deeper) begin
                    w_step_b = 1'b1;
                    w_to     = ST_LEVEL_B;
                end else begin
                    w_step_a = !i_status.same_node;
                    w_step_b = !i_status.same_node;
                end
            end
            ST_JOINT: begin
                w_walk   = 1'b1;
                w_step_a = !i_status.same_node;
                w_step_b = !i_status.same_node;
            end
            default: begin
                w_walk = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_LEVEL;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            default: begin
                if (!w_walk) begin
                    n_state = ST_IDLE;
                end else if (w_step_a || w_step_b) begin
                    if (i_status.bound_hit) begin
                        // drop the query with a fault
                        o_cmd.finish = 1'b1;
                        o_cmd.fault  = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.climb_a = w_step_a;
                        o_cmd.climb_b = w_step_b;
                        n_state       = w_to;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.finish;
        end
    end

    assign busy    = r_state != ST_IDLE;
    assign o_valid = r_valid;

endmodule

// ===== hdl/tree_lowest_common_ancestor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor: lowest common ancestor by parent walk
// Parent/depth tables loaded by write items; queries climb the tree.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low.
//   i_func = 0 writes one node's parent and depth; it gives no result, busy
//   stays low, and writes can follow in every cycle.
//   i_func = 1 queries the common ancestor of i_first_node and i_second_node.
//   busy then stays high while the node registers climb one parent link per
//   cycle (the deeper node alone until depths match, then both together).
//   A query holds busy through its climb steps (0 for equal nodes, at
//   most NODES) and a finishing step; the result is on o_ancestor/o_fault
//   with o_valid for one cycle, starting in the cycle in which busy falls,
//   and a new item may transfer in that same cycle. The climb rate is set
//   by the two registered read ports of the table memory, one lookup per
//   node per cycle.
//   If more than NODES steps are needed, the query ends with o_fault high
//   and o_ancestor zero.
//   The receiver cannot stall: each result is shown exactly once.
//   Reset returns the sequencer to idle and clears the strobe; table
//   contents are not cleared and must be written before they are queried.
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor #(
    parameter int NODES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_func,
    input  tlca_pkg::t_field i_node,
    input  tlca_pkg::t_field i_parent_node,
    input  tlca_pkg::t_field i_node_depth,
    input  tlca_pkg::t_field i_first_node,
    input  tlca_pkg::t_field i_second_node,
    output logic             o_valid,
    output tlca_pkg::t_field o_ancestor,
    output logic             o_fault
);
    import tlca_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: decides per cycle which node climbs and when to finish.
    tlca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // Tables, node registers and step bound.
    tlca_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_node        (i_node),
        .i_parent_node (i_parent_node),
        .i_node_depth  (i_node_depth),
        .i_first_node  (i_first_node),
        .i_second_node (i_second_node),
        .o_status      (w_status),
        .o_ancestor    (o_ancestor),
        .o_fault       (o_fault)
    );

endmodule

// ===== hdl/tlca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_checker: port-level checks for the ancestor block
// Watches the command handshake and the result strobe; bound to the top.
// ----------------------------------------------------------------------------
module tlca_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_func,
    input logic             o_valid,
    input tlca_pkg::t_field o_ancestor,
    input logic             o_fault
);
    import tlca_pkg::*;

    // A query transfer always occupies the block.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func) |=> busy)
        else $error("query transfer did not raise busy");

    // A write transfer leaves the block idle with no result.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_func) |=> (!busy && !o_valid))
        else $error("write transfer produced work or a result");

    // The end of a query shows its result.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("query ended without a result");

    // A result only follows a query.
    a_result_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished query");

    // A fault carries a zero ancestor.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_ancestor == '0))
        else $error("fault result with nonzero ancestor");

endmodule

bind tree_lowest_common_ancestor tlca_checker u_tlca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_func     (i_func),
    .o_valid    (o_valid),
    .o_ancestor (o_ancestor),
    .o_fault    (o_fault)
);

// ===== tb/tb_tree_lowest_common_ancestor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_lowest_common_ancestor: self-checking bench for the LCA block
// Loads a full parent/depth chain by write transfers, then asks ancestor
// queries. A directed table covers the chain extremes, equal nodes and
// step-bound faults. Random trees follow: shallow, deep and mixed shapes,
// with noise writes that may break the tree. Each result is checked
// against a typed-in answer or an in-bench tree walk.
// ----------------------------------------------------------------------------
module tb_tree_lowest_common_ancestor;
    import tlca_pkg::*;

    localparam int NODES          = 128;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    // Hang guard, far above the slowest run: ~400 transfers, each no
    // longer than a query at the step bound plus the sender gap.
    localparam int CYCLE_LIMIT    = 1_000_000;
    // Long enough for a query at the step bound and its strobe.
    localparam int SETTLE_CYCLES  = NODES + 8;
    localparam int SHOWN_FAILURES = 10;
    localparam int N_PHASES       = 3;
    localparam int N_DIRECTED     = 22;
    // Nodes rewritten into a fresh tree per random phase.
    localparam int TREE_NODES     = 40;

    // Sender idle share per random phase, and the share of tree nodes that
    // hang below the previous one (high share gives a deep, chain-like tree).
    localparam int IDLE_PCT  [N_PHASES] = '{21, 52, 0};
    localparam int CHAIN_PCT [N_PHASES] = '{40, 97, 5};

    typedef enum logic {
        FN_WRITE = 1'b0,
        FN_QUERY = 1'b1
    } t_func;

    typedef struct packed {
        t_field ancestor;
        logic   fault;
    } t_answer;

    // One directed transfer; the answer is typed in only where typed is set.
    typedef struct packed {
        t_func  func;
        t_field node;
        t_field parent;
        t_field depth;
        t_field first;
        t_field second;
        logic   typed;
        t_field ref_ancestor;
        logic   ref_fault;
    } t_row;

    // The directed rows run on a chain: node n hangs below n-1 at depth n.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // equal nodes answer at once, at both ends of the index range
        '{FN_QUERY,   0,   0,   0,   0,   0, 1'b1,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0, 127, 127, 1'b1, 127, 1'b0},
        // full-depth climbs in both argument orders, then shorter climbs
        '{FN_QUERY,   0,   0,   0,   0, 127, 1'b1,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0, 127,   0, 1'b1,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0, 127, 126, 1'b1, 126, 1'b0},
        '{FN_QUERY,   0,   0,   0,  85,  42, 1'b1,  42, 1'b0},
        // a query ignores the write fields, and leaves the tables alone
        '{FN_QUERY, 127, 127, 127,   3, 100, 1'b1,   3, 1'b0},
        '{FN_QUERY,   0,   0,   0, 100,   3, 1'b1,   3, 1'b0},
        // self loop on the deepest node: levelling never ends
        '{FN_WRITE, 127, 127, 127, 127, 127, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0, 127,   5, 1'b1,   0, 1'b1},
        '{FN_QUERY,   0,   0,   0, 127, 127, 1'b1, 127, 1'b0},
        '{FN_WRITE, 127, 126, 127,   0,   0, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0,   5, 127, 1'b1,   5, 1'b0},
        // node 1 loops on itself at depth 0: the joint climb never meets
        '{FN_WRITE,   1,   1,   0,   0,   0, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0,   1,   0, 1'b1,   0, 1'b1},
        '{FN_QUERY,   0,   0,   0, 127,   0, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0,  64,  77, 1'b0,   0, 1'b0},
        '{FN_WRITE,   1,   0,   1,   0,   0, 1'b0,   0, 1'b0},
        // graft node 64 under the root; depths below it go stale
        '{FN_WRITE,  64,   0,   1,   0,   0, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0, 127,  63, 1'b0,   0, 1'b0},
        '{FN_QUERY,   0,   0,   0,  65,   2, 1'b0,   0, 1'b0},
        '{FN_WRITE,  64,  63,  64,   0,   0, 1'b0,   0, 1'b0}
    };

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   start         = 1'b0;
    logic   i_func        = 1'b0;
    t_field i_node        = '0;
    t_field i_parent_node = '0;
    t_field i_node_depth  = '0;
    t_field i_first_node  = '0;
    t_field i_second_node = '0;
    logic   busy;
    logic   o_valid;
    t_field o_ancestor;
    logic   o_fault;

    // Shadow tables, updated at each accepted write transfer.
    t_field  parent_mem [NODES];
    t_field  depth_mem  [NODES];
    // Answers owed by the block, oldest first.
    t_answer answers_due [$];
    int      fail_count      = 0;
    int      sender_idle_pct = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    tree_lowest_common_ancestor #(
        .NODES(NODES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_node       (i_node),
        .i_parent_node(i_parent_node),
        .i_node_depth (i_node_depth),
        .i_first_node (i_first_node),
        .i_second_node(i_second_node),
        .o_valid      (o_valid),
        .o_ancestor   (o_ancestor),
        .o_fault      (o_fault)
    );

    // Walk the shadow tables: level the deeper node, then climb both until
    // they meet. Every climb counts one step; a climb past NODES steps
    // ends the walk with a fault and a zero ancestor.
    function automatic t_answer lca_of(input t_field first, input t_field second);
        int      a;
        int      b;
        int      swap;
        int      steps;
        t_answer res;
        a     = int'(first) % NODES;
        b     = int'(second) % NODES;
        steps = 0;
        res   = '0;
        if (a == b) begin
            res.ancestor = t_field'(a);
            return res;
        end
        if (depth_mem[a] < depth_mem[b]) begin
            swap = a;
            a    = b;
            b    = swap;
        end
        while (depth_mem[a] > depth_mem[b]) begin
            if (steps >= NODES) begin
                res.fault = 1'b1;
                return res;
            end
            a = int'(parent_mem[a]) % NODES;
            steps++;
        end
        while (a != b) begin
            if (steps >= NODES) begin
                res.fault = 1'b1;
                return res;
            end
            a = int'(parent_mem[a]) % NODES;
            b = int'(parent_mem[b]) % NODES;
            steps++;
        end
        res.ancestor = t_field'(a);
        return res;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Drive one item from a falling edge and hold it until the block takes
    // it. Idle cycles go in front at random. Update the shadow tables or
    // queue the owed answer at the accepting edge.
    task automatic transfer(input t_func func, input t_field node, input t_field parent,
                            input t_field depth, input t_field first, input t_field second,
                            input logic typed = 1'b0, input t_field ref_ancestor = '0,
                            input logic ref_fault = 1'b0);
        t_answer owed;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_node        <= node;
        i_parent_node <= parent;
        i_node_depth  <= depth;
        i_first_node  <= first;
        i_second_node <= second;
        do @(posedge i_clk); while (busy);
        if (func == FN_WRITE) begin
            parent_mem[int'(node) % NODES] = parent;
            depth_mem[int'(node) % NODES]  = depth;
        end else begin
            if (typed) begin
                owed.ancestor = ref_ancestor;
                owed.fault    = ref_fault;
            end else begin
                owed = lca_of(first, second);
            end
            answers_due = {answers_due, owed};
        end
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed answer has arrived.
    task automatic wait_answers;
        start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        @(negedge i_clk);
    endtask

    // Write a well-formed tree over TREE_NODES nodes picked in random order;
    // the other entries keep what they held. The first node is the root;
    // every later one hangs below an earlier one.
    task automatic grow_tree(input int chain_pct);
        int order [NODES];
        int j;
        int swap;
        int up;
        for (int i = 0; i < NODES; i++) begin
            order[i] = i;
        end
        for (int i = NODES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        transfer(FN_WRITE, t_field'(order[0]), '0, '0,
                 t_field'($urandom), t_field'($urandom));
        for (int i = 1; i < TREE_NODES; i++) begin
            up = ($urandom_range(99) < chain_pct) ? order[i-1] : order[$urandom_range(i - 1)];
            transfer(FN_WRITE, t_field'(order[i]), t_field'(up), t_field'(depth_mem[up] + 7'd1),
                     t_field'($urandom), t_field'($urandom));
        end
    endtask

    // Ask about a random pair: sometimes one node twice, often a node and
    // one of its ancestors a few links up, otherwise two unrelated nodes.
    task automatic ask_random;
        t_field a;
        t_field b;
        int     hops;
        logic   flip;
        a    = t_field'($urandom_range(NODES - 1));
        flip = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: begin
                b = a;
            end
            1, 2, 3: begin
                b    = a;
                hops = $urandom_range(8);
                repeat (hops) b = parent_mem[b];
            end
            default: begin
                b = t_field'($urandom_range(NODES - 1));
            end
        endcase
        transfer(FN_QUERY, t_field'($urandom), t_field'($urandom), t_field'($urandom),
                 flip ? b : a, flip ? a : b);
    endtask

    // Check each strobed result against the oldest owed answer.
    always @(posedge i_clk) begin
        t_answer due;
        if (o_valid) begin
            if (answers_due.size() == 0) begin
                note_failure($sformatf("result with nothing owed: ancestor %0d fault %0b",
                                       o_ancestor, o_fault));
            end else begin
                due = answers_due.pop_front();
                if (o_ancestor !== due.ancestor || o_fault !== due.fault) begin
                    note_failure($sformatf("ancestor %0d fault %0b, wanted ancestor %0d fault %0b",
                                           o_ancestor, o_fault, due.ancestor, due.fault));
                end
            end
        end
    end

    // Stop a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load a single chain so every entry is written before any query:
        // node n below n-1 at depth n, node 0 the root.
        sender_idle_pct = IDLE_PCT[0];
        for (int n = 0; n < NODES; n++) begin
            transfer(FN_WRITE, t_field'(n), t_field'((n == 0) ? 0 : n - 1), t_field'(n),
                     t_field'($urandom), t_field'($urandom));
        end

        foreach (DIRECTED_ROWS[r]) begin
            transfer(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].node, DIRECTED_ROWS[r].parent,
                     DIRECTED_ROWS[r].depth, DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].second,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].ref_ancestor,
                     DIRECTED_ROWS[r].ref_fault);
        end
        wait_answers();

        // Each phase: a fresh tree, queries on it, then noise writes that
        // may leave loops or stale depths, and more queries on the wreck.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            sender_idle_pct = IDLE_PCT[phase];
            grow_tree(CHAIN_PCT[phase]);
            repeat (30) ask_random();
            wait_answers();
            repeat (4) begin
                transfer(FN_WRITE, t_field'($urandom), t_field'($urandom), t_field'($urandom),
                         t_field'($urandom), t_field'($urandom));
            end
            repeat (10) ask_random();
            wait_answers();
        end

        // Let any stray strobe show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
